// File: src/csev_pkg.sv
// ----------------------------------------------------------------------------
// csev_pkg: shared types and constants of the cosine series evaluator
// Fixed field widths, fixed-point constants, green weights and the stage
// control word that travels between the pipeline modules.
// ----------------------------------------------------------------------------
package csev_pkg;

    localparam int COS_TABLE_BITS_DEF = 10;
    localparam int ACC_WIDTH_DEF      = 40;

    localparam int ANGLE_W = 16;
    localparam int COEFF_W = 16;
    localparam int CHEB_W  = 16;
    localparam int PROD_W  = 32;
    localparam int TERM_W  = 18;
    localparam int OUT_W   = 32;
    localparam int WGT_W   = 18;
    localparam int GSUM_W  = 50;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 128;

    // 1.0 in Q1.14.
    localparam logic signed [CHEB_W-1:0] Q14_ONE = 16'sd16384;

    // pi in unsigned Q30, used to build the quarter-wave table.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Green weights in Q16.
    localparam logic signed [WGT_W-1:0] G_WY = 18'sd91638;
    localparam logic signed [WGT_W-1:0] G_WB = 18'sd6613;
    localparam logic signed [WGT_W-1:0] G_WR = 18'sd19489;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } stage_ctl_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] blue;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] red;
        logic signed [OUT_W-1:0] lum;
    } result_t;

endpackage

// File: src/csev_cos_rom.sv
// ----------------------------------------------------------------------------
// csev_cos_rom: quarter-wave cosine lookup
// Folds the angle into the first quadrant, reads a constant Q1.14 table with
// a registered read, and restores the sign after the read register.
// ----------------------------------------------------------------------------
module csev_cos_rom #(
    parameter int COS_TABLE_BITS = csev_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [csev_pkg::ANGLE_W-1:0]          angle,
    output logic signed [csev_pkg::CHEB_W-1:0]    cos_val
);
    import csev_pkg::*;

    localparam int TBL_N = 1 << COS_TABLE_BITS;

    typedef logic [CHEB_W-1:0] rom_t [TBL_N];

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic longint unsigned trunc_div(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic rom_t build_rom();
        rom_t             rom;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint           sum;
        longint           r;
        for (int i = 0; i < TBL_N; i++)
        begin
            x    = (PI_Q30 * longint'(i)) >> (COS_TABLE_BITS + 1);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 << 30;
            for (int k = 1; k <= 10; k++)
            begin
                term = trunc_div((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
                if ((k & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            r = (sum + 64'sd32768) >>> 16;
            if (r < 0)
                r = 0;
            if (r > 16384)
                r = 16384;
            rom[i] = r[CHEB_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic [1:0]                quad;
    logic [COS_TABLE_BITS-1:0] idx;
    logic [COS_TABLE_BITS-1:0] addr;
    logic                      zero_next;
    logic                      neg_next;

    logic [CHEB_W-1:0]         rom_q_reg;
    logic                      zero_reg;
    logic                      neg_reg;

    assign quad = angle[ANGLE_W-1 -: 2];
    assign idx  = angle[ANGLE_W-3 -: COS_TABLE_BITS];

    // Odd quadrants mirror the index; the mirror of zero is the quarter-wave
    // end point, whose cosine is zero and which lies outside the table.
    assign addr      = quad[0] ? (~idx + 1'b1) : idx;
    assign zero_next = quad[0] && (idx == '0);
    assign neg_next  = quad[1] ^ quad[0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rom_q_reg <= COS_ROM[addr];
            zero_reg  <= zero_next;
            neg_reg   <= neg_next;
        end
    end

    always_comb
    begin
        if (zero_reg)
            cos_val = '0;
        else if (neg_reg)
            cos_val = -$signed(rom_q_reg);
        else
            cos_val = $signed(rom_q_reg);
    end

endmodule

// File: src/csev_lane.sv
// ----------------------------------------------------------------------------
// csev_lane: one channel of the series evaluator
// Multiplies the coefficient by the current Q1.14 Chebyshev value, rounds off
// the 14 fraction bits, then adds to (on first: loads) a saturating accumulator.
// ----------------------------------------------------------------------------
module csev_lane #(
    parameter int ACC_WIDTH = csev_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic signed [csev_pkg::COEFF_W-1:0] coeff,
    input  logic signed [csev_pkg::CHEB_W-1:0]  cheb,
    input  csev_pkg::stage_ctl_t                acc_ctl,
    output logic signed [ACC_WIDTH-1:0]         acc
);
    import csev_pkg::*;

    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [TERM_W-1:0]    term;
    logic signed [ACC_WIDTH-1:0] term_ext;
    logic signed [ACC_WIDTH:0]   sum;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [ACC_WIDTH-1:0] acc_reg;

    assign prod_next = coeff * cheb;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod_rnd = (prod_reg + 32'sd8192) >>> 14;
    assign term     = prod_rnd[TERM_W-1:0];
    assign term_ext = {{(ACC_WIDTH - TERM_W){term[TERM_W-1]}}, term};
    assign sum      = {acc_reg[ACC_WIDTH-1], acc_reg} + {term_ext[ACC_WIDTH-1], term_ext};

    always_comb
    begin
        if (acc_ctl.first)
            acc_next = term_ext;
        else if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
            acc_next = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        else
            acc_next = sum[ACC_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (en && acc_ctl.valid)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: src/csev_merge.sv
// ----------------------------------------------------------------------------
// csev_merge: combines the three lane sums into one result
// Saturates the sums to 32 bits, weights them for green in a registered
// multiply stage, then rounds and saturates the green sum.
// ----------------------------------------------------------------------------
module csev_merge #(
    parameter int ACC_WIDTH = csev_pkg::ACC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [ACC_WIDTH-1:0] acc_lum,
    input  logic signed [ACC_WIDTH-1:0] acc_red,
    input  logic signed [ACC_WIDTH-1:0] acc_blue,
    output logic                        res_valid,
    output csev_pkg::result_t           res
);
    import csev_pkg::*;

    function automatic logic signed [OUT_W-1:0] sat_acc(input logic signed [ACC_WIDTH-1:0] v);
        logic [ACC_WIDTH-OUT_W:0] top;
        top = v[ACC_WIDTH-1:OUT_W-1];
        if ((&top) || !(|top))
            return v[OUT_W-1:0];
        else if (v[ACC_WIDTH-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    logic                     sat_valid_reg;
    logic signed [OUT_W-1:0]  y_sat_reg;
    logic signed [OUT_W-1:0]  r_sat_reg;
    logic signed [OUT_W-1:0]  b_sat_reg;

    logic                     mul_valid_reg;
    logic signed [OUT_W-1:0]  y_reg;
    logic signed [OUT_W-1:0]  r_reg;
    logic signed [OUT_W-1:0]  b_reg;
    logic signed [GSUM_W-1:0] py_reg;
    logic signed [GSUM_W-1:0] pr_reg;
    logic signed [GSUM_W-1:0] pb_reg;
    logic signed [GSUM_W-1:0] py_next;
    logic signed [GSUM_W-1:0] pr_next;
    logic signed [GSUM_W-1:0] pb_next;

    logic signed [GSUM_W-1:0] g_sum;
    logic signed [GSUM_W-1:0] g_shr;
    logic [GSUM_W-OUT_W:0]    g_top;
    logic signed [OUT_W-1:0]  green;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sat_valid_reg <= in_valid;
            mul_valid_reg <= sat_valid_reg;
        end
    end

    assign py_next = y_sat_reg * G_WY;
    assign pr_next = r_sat_reg * G_WR;
    assign pb_next = b_sat_reg * G_WB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_sat_reg <= sat_acc(acc_lum);
            r_sat_reg <= sat_acc(acc_red);
            b_sat_reg <= sat_acc(acc_blue);
            y_reg     <= y_sat_reg;
            r_reg     <= r_sat_reg;
            b_reg     <= b_sat_reg;
            py_reg    <= py_next;
            pr_reg    <= pr_next;
            pb_reg    <= pb_next;
        end
    end

    assign g_sum = py_reg - pb_reg - pr_reg + 50'sd32768;
    assign g_shr = g_sum >>> 16;
    assign g_top = g_shr[GSUM_W-1:OUT_W-1];

    always_comb
    begin
        if ((&g_top) || !(|g_top))
            green = g_shr[OUT_W-1:0];
        else if (g_shr[GSUM_W-1])
            green = {1'b1, {(OUT_W-1){1'b0}}};
        else
            green = {1'b0, {(OUT_W-1){1'b1}}};
    end

    assign res_valid = mul_valid_reg;
    assign res.lum   = y_reg;
    assign res.red   = r_reg;
    assign res.green = green;
    assign res.blue  = b_reg;

endmodule

// File: src/cosine_series_eval_rgb.sv
// ----------------------------------------------------------------------------
// cosine_series_eval_rgb: three-channel cosine series evaluator
// A tlast result passes the s1, lane, merge and output registers to m_tvalid.
// Throughput: one coefficient triple per cycle while s_tready is high.
// The single Chebyshev recurrence loop (one 16x16 multiply) sets the rate.
// s_tready drops only while the output register holds an untaken result and
// another result has reached the end of the merge stage.
// Reset: accumulators zero, recurrence at cos 0 / prev 0 / cur 1.0; the
// cosine table is a constant ROM and needs no fill after reset.
// ----------------------------------------------------------------------------
module cosine_series_eval_rgb #(
    parameter int COS_TABLE_BITS = csev_pkg::COS_TABLE_BITS_DEF,
    parameter int ACC_WIDTH      = csev_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // angle[15:0], coeff_lum[31:16], coeff_red[47:32], coeff_blue[63:48]
    input  logic [csev_pkg::IN_DATA_W-1:0]      s_tdata,
    // first[0]
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sum_lum[31:0], out_red[63:32], out_green[95:64], out_blue[127:96]
    output logic [csev_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import csev_pkg::*;

    logic                      adv;
    logic                      in_fire;

    stage_ctl_t                s1_reg;
    stage_ctl_t                s2_reg;
    stage_ctl_t                s3_reg;
    logic signed [COEFF_W-1:0] cl1_reg;
    logic signed [COEFF_W-1:0] cr1_reg;
    logic signed [COEFF_W-1:0] cb1_reg;

    logic signed [CHEB_W-1:0]  cos_val;
    logic signed [CHEB_W-1:0]  cos_step_reg;
    logic signed [CHEB_W-1:0]  cheb_prev_reg;
    logic signed [CHEB_W-1:0]  cheb_cur_reg;
    logic signed [CHEB_W-1:0]  cheb_cur_next;
    logic signed [CHEB_W-1:0]  cheb_used;
    logic signed [PROD_W-1:0]  rec_prod;
    logic signed [PROD_W-1:0]  rec_rnd;
    logic signed [PROD_W-1:0]  rec_diff;

    logic signed [ACC_WIDTH-1:0] acc_lum;
    logic signed [ACC_WIDTH-1:0] acc_red;
    logic signed [ACC_WIDTH-1:0] acc_blue;

    logic                      res_valid;
    result_t                   res;
    result_t                   out_reg;
    logic                      out_valid_reg;

    // The pipeline moves unless a new result would overwrite one still waiting.
    assign adv      = !(out_valid_reg && !m_tready && res_valid);
    assign s_tready = adv;
    assign in_fire  = s_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= '{valid: in_fire, first: s_tuser, last: s_tlast};
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl1_reg <= $signed(s_tdata[31:16]);
            cr1_reg <= $signed(s_tdata[47:32]);
            cb1_reg <= $signed(s_tdata[63:48]);
        end
    end

    csev_cos_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cos_rom (
        .clk     (clk),
        .en      (adv),
        .angle   (s_tdata[ANGLE_W-1:0]),
        .cos_val (cos_val)
    );

    // Chebyshev recurrence. A first transaction restarts it; stepping from
    // prev = cos and cur = 1.0 gives cur = cos exactly, so it loads directly.
    assign cheb_used = s1_reg.first ? Q14_ONE : cheb_cur_reg;
    assign rec_prod  = cos_step_reg * cheb_cur_reg;
    assign rec_rnd   = (rec_prod + 32'sd4096) >>> 13;
    assign rec_diff  = rec_rnd - {{(PROD_W - CHEB_W){cheb_prev_reg[CHEB_W-1]}}, cheb_prev_reg};

    always_comb
    begin
        if (rec_diff > 32'sd32767)
            cheb_cur_next = 16'sh7fff;
        else if (rec_diff < -32'sd32768)
            cheb_cur_next = 16'sh8000;
        else
            cheb_cur_next = rec_diff[CHEB_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_step_reg  <= '0;
            cheb_prev_reg <= '0;
            cheb_cur_reg  <= Q14_ONE;
        end
        else if (adv && s1_reg.valid)
        begin
            if (s1_reg.first)
            begin
                cos_step_reg  <= cos_val;
                cheb_prev_reg <= Q14_ONE;
                cheb_cur_reg  <= cos_val;
            end
            else
            begin
                cheb_prev_reg <= cheb_cur_reg;
                cheb_cur_reg  <= cheb_cur_next;
            end
        end
    end

    csev_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane_lum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .coeff   (cl1_reg),
        .cheb    (cheb_used),
        .acc_ctl (s2_reg),
        .acc     (acc_lum)
    );

    csev_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane_red (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .coeff   (cr1_reg),
        .cheb    (cheb_used),
        .acc_ctl (s2_reg),
        .acc     (acc_red)
    );

    csev_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane_blue (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .coeff   (cb1_reg),
        .cheb    (cheb_used),
        .acc_ctl (s2_reg),
        .acc     (acc_blue)
    );

    csev_merge #(.ACC_WIDTH(ACC_WIDTH)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_reg.valid && s3_reg.last),
        .acc_lum   (acc_lum),
        .acc_red   (acc_red),
        .acc_blue  (acc_blue),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // A stalled merge stage always has a result waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !s_tready) |-> m_tvalid)
        else $error("merge stall without a pending output transaction");

    // A first transaction restarts the recurrence at 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_reg.valid && s1_reg.first) |=> (cheb_prev_reg == Q14_ONE))
        else $error("recurrence not restarted on first transaction");

    // The table lookup never leaves the Q1.14 unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cos_step_reg <= Q14_ONE) && (cos_step_reg >= -Q14_ONE))
        else $error("cosine step out of range");

endmodule

// File: tb/cosine_series_eval_rgb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cosine_series_eval_rgb_tb: self-checking bench for the cosine series block
// Streams coefficient triples into the evaluator and keeps its own
// fixed-point model of the quarter-wave table, the Chebyshev recurrence and
// the three saturating accumulators. Every result transaction is checked
// field by field against the oldest predicted sum. The input side sends in
// random bursts and the output side stalls in a changing pattern.
// ----------------------------------------------------------------------------
module cosine_series_eval_rgb_tb;

    import csev_pkg::*;

    localparam int TBL_BITS = COS_TABLE_BITS_DEF;
    localparam int TBL_LEN  = 1 << TBL_BITS;
    localparam int ACC_W    = ACC_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 530;
    localparam longint unsigned PI_Q30_C = 64'd3373259426;
    localparam longint ONE_Q14  = 16384;
    localparam longint GREEN_WY = 91638;
    localparam longint GREEN_WB = 6613;
    localparam longint GREEN_WR = 19489;

    typedef struct {
        logic               first;
        logic [15:0]        angle;
        logic signed [15:0] coeff_lum;
        logic signed [15:0] coeff_red;
        logic signed [15:0] coeff_blue;
        logic               last;
    } coeff_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    coeff_item_t pending_items[$];
    result_t     expected_sums[$];
    int          error_count = 0;

    // Model state: quarter-wave table, recurrence and accumulators.
    logic signed [15:0] quarter_cos [TBL_LEN];
    logic signed [15:0] cos_step;
    logic signed [15:0] cheb_prev;
    logic signed [15:0] cheb_cur;
    longint             acc_lum;
    longint             acc_red;
    longint             acc_blue;

    cosine_series_eval_rgb dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Taylor series of cos in unsigned Q30, each term truncated, then rounded to Q14.
    function automatic logic signed [15:0] taylor_cos(int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint          sum;
        longint          r;
        x = (PI_Q30_C * idx) >> (TBL_BITS + 1);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = 64'sd1 <<< 30;
        for (int k = 1; k <= 10; k++)
        begin
            divisor = (2 * k - 1) * (2 * k);
            term = ((term * x2) >> 30) / divisor;
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        r = (sum + 32768) >>> 16;
        if (r < 0)
            r = 0;
        if (r > ONE_Q14)
            r = ONE_Q14;
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] table_entry(int unsigned idx);
        return (idx < TBL_LEN) ? quarter_cos[idx] : 16'sd0;
    endfunction

    function automatic logic signed [15:0] cos_of_angle(logic [15:0] angle);
        int unsigned idx;
        idx = angle[13:0] >> (14 - TBL_BITS);
        unique case (angle[15:14])
            2'd0:    return table_entry(idx);
            2'd1:    return -table_entry(TBL_LEN - idx);
            2'd2:    return -table_entry(idx);
            default: return table_entry(TBL_LEN - idx);
        endcase
    endfunction

    function automatic longint scaled_term(logic signed [15:0] coeff);
        return (longint'(coeff) * longint'(cheb_cur) + 8192) >>> 14;
    endfunction

    // Adds one coefficient triple to the running sums (cleared on a first item),
    // steps the recurrence and, on the closing coefficient, queues the resulting pixel.
    task automatic accumulate_term(input coeff_item_t it);
        longint  nxt;
        longint  y;
        longint  r;
        longint  b;
        longint  g;
        result_t px;
        if (it.first)
        begin
            cos_step = cos_of_angle(it.angle);
            cheb_prev = cos_step;
            cheb_cur = 16'sd16384;
            acc_lum = 0;
            acc_red = 0;
            acc_blue = 0;
        end
        acc_lum = clamp_signed(acc_lum + scaled_term(it.coeff_lum), ACC_W);
        acc_red = clamp_signed(acc_red + scaled_term(it.coeff_red), ACC_W);
        acc_blue = clamp_signed(acc_blue + scaled_term(it.coeff_blue), ACC_W);
        nxt = ((longint'(cos_step) * longint'(cheb_cur) + 4096) >>> 13)
              - longint'(cheb_prev);
        cheb_prev = cheb_cur;
        cheb_cur = 16'(clamp_signed(nxt, 16));
        if (it.last)
        begin
            y = clamp_signed(acc_lum, 32);
            r = clamp_signed(acc_red, 32);
            b = clamp_signed(acc_blue, 32);
            g = y * GREEN_WY - b * GREEN_WB - r * GREEN_WR;
            g = clamp_signed((g + 32768) >>> 16, 32);
            px.lum = y[31:0];
            px.red = r[31:0];
            px.green = g[31:0];
            px.blue = b[31:0];
            expected_sums.push_back(px);
        end
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            note_error($sformatf("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                                 name, $signed(want), want, $signed(got), got));
    endtask

    function automatic void add_item(logic first, logic [15:0] angle, logic signed [15:0] cl,
                                     logic signed [15:0] cr, logic signed [15:0] cb,
                                     logic last);
        coeff_item_t it;
        it.first = first;
        it.angle = angle;
        it.coeff_lum = cl;
        it.coeff_red = cr;
        it.coeff_blue = cb;
        it.last = last;
        pending_items.push_back(it);
    endfunction

    function automatic logic signed [15:0] pick_coeff();
        unique case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        unique case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'(16'h4000 * $urandom_range(0, 3));
            2:       return 16'(16'h3FFF + 16'h4000 * $urandom_range(0, 3));
            3:       return 16'($urandom_range(0, 63));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Input side: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : feed_side
        coeff_item_t on_bus;
        int          burst_left;
        int          gap_left;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                accumulate_term(on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.coeff_blue, on_bus.coeff_red, on_bus.coeff_lum,
                                on_bus.angle};
                    s_tuser <= on_bus.first;
                    s_tlast <= on_bus.last;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: the stall pattern changes as bits 8:7 of the cycle counter step.
    always @(posedge clk or negedge rst_n)
    begin : drain_side
        logic [15:0] rx_cycle;
        result_t     want;
        result_t     got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    note_error($sformatf("result transaction with nothing expected: 0x%032h",
                                         m_tdata));
                end
                else
                begin
                    want = expected_sums.pop_front();
                    got = m_tdata;
                    compare_field("sum_lum", want.lum, got.lum);
                    compare_field("out_red", want.red, got.red);
                    compare_field("out_green", want.green, got.green);
                    compare_field("out_blue", want.blue, got.blue);
                end
            end
            rx_cycle = rx_cycle + 16'd1;
            unique case (rx_cycle[8:7])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= (rx_cycle[2:0] == 3'd0);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    initial
    begin : limit_guard
        #2_000_000;
        $display("cosine_series_eval_rgb_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int len;
        int kind;
        int extra_first;

        for (int i = 0; i < TBL_LEN; i++)
            quarter_cos[i] = taylor_cos(i);
        cos_step = 16'sd0;
        cheb_prev = 16'sd0;
        cheb_cur = 16'sd16384;
        acc_lum = 0;
        acc_red = 0;
        acc_blue = 0;

        // Directed: no first since reset, then continuation after a result.
        add_item(1'b0, 16'h1234, 16'sd1000, -16'sd1000, 16'sd2000, 1'b0);
        add_item(1'b0, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sd0, 1'b1);
        add_item(1'b0, 16'h0000, -16'sd1, 16'sd1, 16'sd4096, 1'b1);
        // One-term series at the coefficient extremes.
        add_item(1'b1, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        add_item(1'b1, 16'h0000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        add_item(1'b1, 16'h8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
        // Quadrant boundaries, where the mirrored index reads past the table.
        add_item(1'b1, 16'h4000, 16'sd4096, 16'sd4096, 16'sd4096, 1'b0);
        add_item(1'b0, 16'h0000, 16'sd4096, -16'sd4096, 16'sh7FFF, 1'b0);
        add_item(1'b0, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sd4096, 1'b1);
        add_item(1'b1, 16'hC000, 16'sd100, 16'sd200, 16'sd300, 1'b0);
        add_item(1'b0, 16'h5555, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1);
        add_item(1'b1, 16'hFFFF, 16'sh8000, 16'sd1, 16'sh7FFF, 1'b0);
        add_item(1'b0, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        add_item(1'b0, 16'hAAAA, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
        add_item(1'b1, 16'h3FFF, 16'sd12345, -16'sd12345, 16'sd777, 1'b0);
        add_item(1'b0, 16'h8000, 16'sd12345, 16'sd12345, -16'sd777, 1'b1);
        add_item(1'b1, 16'h7FF0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        // A new first in mid-series restarts everything.
        add_item(1'b1, 16'hBFFF, 16'sh7FFF, 16'sh8000, 16'sd0, 1'b0);
        add_item(1'b0, 16'h0000, 16'sd2048, 16'sd2048, 16'sd2048, 1'b0);
        add_item(1'b0, 16'h0000, -16'sd2048, 16'sd2048, -16'sd2048, 1'b1);
        add_item(1'b1, 16'h0010, 16'sd1, -16'sd1, 16'sd0, 1'b1);

        // Random series, mostly well formed, some noise and broken ones.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
                for (int k = 0; k < len; k++)
                    add_item(k == 0, pick_angle(), pick_coeff(), pick_coeff(), pick_coeff(),
                             k == len - 1);
            end
            else if (kind == 8)
            begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    add_item(1'($urandom_range(0, 1)), pick_angle(), pick_coeff(),
                             pick_coeff(), pick_coeff(), 1'($urandom_range(0, 1)));
            end
            else
            begin
                len = $urandom_range(2, 8);
                extra_first = $urandom_range(1, len - 1);
                for (int k = 0; k < len; k++)
                    add_item(k == 0 || k == extra_first, pick_angle(), pick_coeff(),
                             pick_coeff(), pick_coeff(), 1'b0);
            end
            sent += len;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_sums.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (error_count == 0)
            $display("cosine_series_eval_rgb_tb: done, clean");
        else
            $display("cosine_series_eval_rgb_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
src/csev_pkg.sv
src/csev_cos_rom.sv
src/csev_lane.sv
src/csev_merge.sv
src/cosine_series_eval_rgb.sv
tb/cosine_series_eval_rgb_tb.sv
